// File: src/dtq_pkg.sv
package dtq_pkg;

    localparam int ID_W    = 16;
    localparam int DLY_W   = 16;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int NRES_W  = 5;

    localparam logic [NRES_W-1:0] MAX_RESULTS = 5'd16;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

    localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_RELEASED = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DLY_W-1:0] delta;
    } t_entry;

endpackage

// File: src/dtq_if.sv
interface dtq_in_if;
    logic                      valid;
    logic                      ready;
    logic [dtq_pkg::ACT_W-1:0] action;
    logic [dtq_pkg::ID_W-1:0]  waiter_id;
    logic [dtq_pkg::DLY_W-1:0] delay_ticks;

    modport source(output valid, action, waiter_id, delay_ticks, input ready);
    modport sink(input valid, action, waiter_id, delay_ticks, output ready);
endinterface

interface dtq_out_if;
    logic                       valid;
    logic                       ready;
    logic [dtq_pkg::ID_W-1:0]   released_id;
    logic [dtq_pkg::STAT_W-1:0] status;
    logic                       last;

    modport source(output valid, released_id, status, last, input ready);
    modport sink(input valid, released_id, status, last, output ready);
endinterface

// File: src/delta_timer_queue.sv
// An item is taken only while the block is idle, and one item is worked on at a time. Its first
// result is registered from S_START for a refused or appended insert, an empty queue or an unused
// action; from S_REL for a flush or a tick, where a release is held until the next head shows
// whether it is last; and from S_PUT, after S_WALK has moved the later entries, for an insert
// that walks the queue. Reset (synchronous, active low) empties the queue; memory is kept.
module delta_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtq_in_if.sink    i_in,
    dtq_out_if.source o_res
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int IW = dtq_pkg::ID_W;
    localparam int DW = dtq_pkg::DLY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_PUT,
        S_REL,
        S_FIX
    } t_state;

    // Maps a position in the queue to its slot in the circular memory.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(pos);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return AW'(sum);
    endfunction

    function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a,
                                              input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DW] ? {DW{1'b1}} : s[DW-1:0];
    endfunction

    dtq_pkg::t_entry r_mem [QUEUE_DEPTH];
    dtq_pkg::t_entry r_rdata;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [AW-1:0]               r_head, n_head;
    logic [DW-1:0]               r_tail_abs, n_tail_abs;
    logic [DW-1:0]               r_abs, n_abs;
    logic [CW-1:0]               r_idx, n_idx;
    logic [dtq_pkg::ACT_W-1:0]   r_act, n_act;
    logic [IW-1:0]               r_id, n_id;
    logic [DW-1:0]               r_delay, n_delay;
    logic                        r_first, n_first;
    logic                        r_pend, n_pend;
    logic [IW-1:0]               r_pid, n_pid;
    logic [dtq_pkg::NRES_W-1:0]  r_nres, n_nres;
    logic [DW-1:0]               r_carry, n_carry;
    logic                        r_ovalid, n_ovalid;
    logic [IW-1:0]               r_oid, n_oid;
    logic [dtq_pkg::STAT_W-1:0]  r_ostat, n_ostat;
    logic                        r_olast, n_olast;

    logic                        s_we;
    logic [AW-1:0]               s_waddr;
    dtq_pkg::t_entry             s_wdata;
    logic [AW-1:0]               s_raddr;
    logic                        s_emit;
    logic [IW-1:0]               s_eid;
    logic [dtq_pkg::STAT_W-1:0]  s_est;
    logic                        s_elast;
    logic                        s_pop;

    logic                        out_free;
    logic [CW-1:0]               tail_pos;
    logic [AW-1:0]               nxt_head;
    logic [DW-1:0]               walk_lower;
    logic                        walk_stop;
    logic [DW-1:0]               tick_delta;
    logic                        tick_more;
    logic                        flush_last;

    assign out_free   = !r_ovalid || o_res.ready;
    assign tail_pos   = (r_count == '0) ? '0 : r_count - CW'(1);
    assign nxt_head   = phys(r_head, CW'(1));
    assign walk_lower = r_abs - r_rdata.delta;
    assign walk_stop  = (walk_lower <= r_delay) || (r_idx == '0);
    assign tick_delta = (r_first && r_rdata.delta != '0) ? r_rdata.delta - DW'(1)
                                                          : r_rdata.delta;
    // Another release follows only while the head has run out and the per-item limit allows.
    assign tick_more  = (r_count != '0) && (tick_delta == '0)
                        && (r_nres < dtq_pkg::MAX_RESULTS);
    assign flush_last = (r_count == CW'(1))
                        || (r_nres == dtq_pkg::MAX_RESULTS - dtq_pkg::NRES_W'(1));

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_ovalid;
    assign o_res.released_id = r_oid;
    assign o_res.status      = r_ostat;
    assign o_res.last        = r_olast;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_tail_abs = r_tail_abs;
        n_abs      = r_abs;
        n_idx      = r_idx;
        n_act      = r_act;
        n_id       = r_id;
        n_delay    = r_delay;
        n_first    = r_first;
        n_pend     = r_pend;
        n_pid      = r_pid;
        n_nres     = r_nres;
        n_carry    = r_carry;
        s_we       = 1'b0;
        s_waddr    = r_head;
        s_wdata    = '0;
        s_raddr    = r_head;
        s_emit     = 1'b0;
        s_eid      = '0;
        s_est      = dtq_pkg::ST_NONE;
        s_elast    = 1'b1;
        s_pop      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_act   = i_in.action;
                    n_id    = i_in.waiter_id;
                    n_delay = i_in.delay_ticks;
                    n_state = S_START;
                end
            end
            S_START: begin
                case (r_act)
                    dtq_pkg::ACT_INSERT: begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            if (out_free) begin
                                s_emit  = 1'b1;
                                s_est   = dtq_pkg::ST_FULL;
                                n_state = S_IDLE;
                            end
                        end else if (r_count == '0 || r_tail_abs <= r_delay) begin
                            // The new waiter goes behind every queued entry.
                            if (out_free) begin
                                s_we          = 1'b1;
                                s_waddr       = phys(r_head, r_count);
                                s_wdata.id    = r_id;
                                s_wdata.delta = r_delay - ((r_count == '0) ? '0 : r_tail_abs);
                                n_count       = r_count + CW'(1);
                                n_tail_abs    = r_delay;
                                s_emit        = 1'b1;
                                s_est         = dtq_pkg::ST_ACCEPTED;
                                n_state       = S_IDLE;
                            end
                        end else begin
                            s_raddr = phys(r_head, tail_pos);
                            n_idx   = tail_pos;
                            n_abs   = r_tail_abs;
                            n_state = S_WALK;
                        end
                    end
                    dtq_pkg::ACT_TICK, dtq_pkg::ACT_FLUSH: begin
                        if (r_count == '0) begin
                            if (out_free) begin
                                s_emit  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_first = 1'b1;
                            n_pend  = 1'b0;
                            n_nres  = '0;
                            n_carry = '0;
                            n_state = S_REL;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            s_emit  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_WALK: begin
                // Walking back from the tail: each entry due later than the new waiter
                // moves up one place, and the one that ends up right behind it takes
                // the remaining difference as its delta.
                s_we          = 1'b1;
                s_waddr       = phys(r_head, r_idx + CW'(1));
                s_wdata.id    = r_rdata.id;
                s_wdata.delta = walk_stop ? r_abs - r_delay : r_rdata.delta;
                n_abs         = walk_lower;
                if (walk_stop) begin
                    n_state = S_PUT;
                end else begin
                    n_idx   = r_idx - CW'(1);
                    s_raddr = phys(r_head, r_idx - CW'(1));
                end
            end
            S_PUT: begin
                if (out_free) begin
                    s_we          = 1'b1;
                    s_waddr       = phys(r_head, r_idx);
                    s_wdata.id    = r_id;
                    s_wdata.delta = r_delay - r_abs;
                    n_count       = r_count + CW'(1);
                    s_emit        = 1'b1;
                    s_est         = dtq_pkg::ST_ACCEPTED;
                    n_state       = S_IDLE;
                end
            end
            S_REL: begin
                if (r_act == dtq_pkg::ACT_FLUSH) begin
                    if (out_free) begin
                        s_emit  = 1'b1;
                        s_eid   = r_rdata.id;
                        s_est   = dtq_pkg::ST_RELEASED;
                        s_elast = flush_last;
                        s_pop   = 1'b1;
                        n_carry = sat_add(r_rdata.delta, r_carry);
                        n_nres  = r_nres + dtq_pkg::NRES_W'(1);
                        if (flush_last) begin
                            n_state = (r_count == CW'(1)) ? S_IDLE : S_FIX;
                        end
                    end
                end else if (r_pend) begin
                    // The held release is emitted once the next head shows whether it is last.
                    if (out_free) begin
                        s_emit  = 1'b1;
                        s_eid   = r_pid;
                        s_est   = dtq_pkg::ST_RELEASED;
                        s_elast = !tick_more;
                        if (tick_more) begin
                            s_pop  = 1'b1;
                            n_pid  = r_rdata.id;
                            n_nres = r_nres + dtq_pkg::NRES_W'(1);
                        end else begin
                            n_pend  = 1'b0;
                            n_state = S_IDLE;
                        end
                    end
                end else if (tick_delta == '0) begin
                    s_pop   = 1'b1;
                    n_pid   = r_rdata.id;
                    n_pend  = 1'b1;
                    n_nres  = dtq_pkg::NRES_W'(1);
                    n_first = 1'b0;
                    if (r_rdata.delta != '0) begin
                        n_tail_abs = r_tail_abs - DW'(1);
                    end
                end else if (out_free) begin
                    s_we          = 1'b1;
                    s_waddr       = r_head;
                    s_wdata.id    = r_rdata.id;
                    s_wdata.delta = tick_delta;
                    n_tail_abs    = r_tail_abs - DW'(1);
                    s_emit        = 1'b1;
                    n_state       = S_IDLE;
                end
                if (s_pop) begin
                    n_head  = nxt_head;
                    n_count = r_count - CW'(1);
                    s_raddr = nxt_head;
                end
            end
            S_FIX: begin
                // A flush that stopped early folds the released deadline into the new head.
                s_we          = 1'b1;
                s_waddr       = r_head;
                s_wdata.id    = r_rdata.id;
                s_wdata.delta = sat_add(r_rdata.delta, r_carry);
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = r_ovalid;
        n_oid    = r_oid;
        n_ostat  = r_ostat;
        n_olast  = r_olast;
        if (s_emit) begin
            n_ovalid = 1'b1;
            n_oid    = s_eid;
            n_ostat  = s_est;
            n_olast  = s_elast;
        end else if (o_res.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_first  <= 1'b0;
            r_pend   <= 1'b0;
            r_nres   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_first  <= n_first;
            r_pend   <= n_pend;
            r_nres   <= n_nres;
            r_ovalid <= n_ovalid;
        end
        r_tail_abs <= n_tail_abs;
        r_abs      <= n_abs;
        r_idx      <= n_idx;
        r_act      <= n_act;
        r_id       <= n_id;
        r_delay    <= n_delay;
        r_pid      <= n_pid;
        r_carry    <= n_carry;
        r_oid      <= n_oid;
        r_ostat    <= n_ostat;
        r_olast    <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_waddr] <= s_wdata;
        end
        r_rdata <= r_mem[s_raddr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !s_we)
        else $error("entry memory written while idle");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |=> (r_count == $past(r_count) - CW'(1)))
        else $error("release did not shrink the queue by one");

    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat != dtq_pkg::ST_RELEASED) |-> (r_oid == '0))
        else $error("non-release result carries a waiter id");

endmodule

// File: tb/tb.sv
module tb;

    localparam int DEPTH = 16;
    localparam logic [dtq_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 150;
    // Once this few items remain, both sides stop idling.
    localparam int QUIET_TAIL = 40;

    typedef struct {
        logic [dtq_pkg::ACT_W-1:0] action;
        logic [dtq_pkg::ID_W-1:0]  waiter_id;
        logic [dtq_pkg::DLY_W-1:0] delay;
    } t_request;

    typedef struct {
        logic [dtq_pkg::ID_W-1:0]   id;
        logic [dtq_pkg::STAT_W-1:0] status;
        logic                       last;
    } t_release;

    logic i_clk;
    logic i_rst_n;

    dtq_in_if  in_bus();
    dtq_out_if res_bus();

    delta_timer_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_res  (res_bus)
    );

    t_request pending[$];
    t_release due_results[$];

    // Shadow copy of the delta list.
    logic [dtq_pkg::ID_W-1:0]  list_ids[DEPTH];
    logic [dtq_pkg::DLY_W-1:0] list_deltas[DEPTH];
    int                        list_len;

    int       fail_count;
    int       send_gap;
    int       recv_gap;
    int       send_rate;
    int       recv_rate;
    int       window_cnt;
    logic     tail_calm;
    t_release seen;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic add_release(input logic [dtq_pkg::ID_W-1:0] id,
                               input logic [dtq_pkg::STAT_W-1:0] status);
        t_release r;
        r.id     = id;
        r.status = status;
        r.last   = 1'b0;
        due_results.push_back(r);
    endtask

    task automatic drop_head();
        for (int i = 1; i < list_len; i++) begin
            list_ids[i-1]    = list_ids[i];
            list_deltas[i-1] = list_deltas[i];
        end
        list_len--;
    endtask

    task automatic advance_timer_list(input t_request rq);
        int                        start;
        int                        pos;
        logic [dtq_pkg::DLY_W-1:0] rest;
        logic [dtq_pkg::DLY_W-1:0] gone;
        logic [dtq_pkg::DLY_W:0]   acc;
        t_release                  final_beat;
        start = due_results.size();
        case (rq.action)
            dtq_pkg::ACT_INSERT: begin
                if (list_len >= DEPTH) begin
                    add_release('0, dtq_pkg::ST_FULL);
                end else begin
                    pos  = 0;
                    rest = rq.delay;
                    while (pos < list_len && list_deltas[pos] <= rest) begin
                        rest = rest - list_deltas[pos];
                        pos++;
                    end
                    if (pos < list_len) list_deltas[pos] = list_deltas[pos] - rest;
                    for (int i = list_len; i > pos; i--) begin
                        list_ids[i]    = list_ids[i-1];
                        list_deltas[i] = list_deltas[i-1];
                    end
                    list_ids[pos]    = rq.waiter_id;
                    list_deltas[pos] = rest;
                    list_len++;
                    add_release('0, dtq_pkg::ST_ACCEPTED);
                end
            end
            dtq_pkg::ACT_TICK: begin
                if (list_len > 0) begin
                    if (list_deltas[0] != 0) list_deltas[0] = list_deltas[0] - 1'b1;
                    while (list_len > 0 && list_deltas[0] == 0 &&
                           due_results.size() - start < dtq_pkg::MAX_RESULTS) begin
                        add_release(list_ids[0], dtq_pkg::ST_RELEASED);
                        drop_head();
                    end
                end
            end
            dtq_pkg::ACT_FLUSH: begin
                while (list_len > 0 && due_results.size() - start < dtq_pkg::MAX_RESULTS) begin
                    gone = list_deltas[0];
                    add_release(list_ids[0], dtq_pkg::ST_RELEASED);
                    drop_head();
                    // Fold the released delta into the new head so deadlines survive
                    // a flush that stops early.
                    if (list_len > 0) begin
                        acc = {1'b0, list_deltas[0]} + {1'b0, gone};
                        list_deltas[0] = acc[dtq_pkg::DLY_W] ? '1 : acc[dtq_pkg::DLY_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        if (due_results.size() == start) add_release('0, dtq_pkg::ST_NONE);
        final_beat      = due_results.pop_back();
        final_beat.last = 1'b1;
        due_results.push_back(final_beat);
    endtask

    task automatic plan(input logic [dtq_pkg::ACT_W-1:0] action,
                        input logic [dtq_pkg::ID_W-1:0] id,
                        input logic [dtq_pkg::DLY_W-1:0] delay);
        t_request rq;
        rq.action    = action;
        rq.waiter_id = id;
        rq.delay     = delay;
        pending.push_back(rq);
    endtask

    function automatic logic [dtq_pkg::DLY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return dtq_pkg::DLY_W'($urandom_range(0, 6));
        if (r < 85) return dtq_pkg::DLY_W'($urandom_range(0, 40));
        if (r < 95) return dtq_pkg::DLY_W'($urandom);
        return (r < 97) ? '1 : '0;
    endfunction

    // Sender: holds a beat until it is taken, otherwise idles in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!(in_bus.valid && !in_bus.ready)) begin
            if (in_bus.valid) void'(pending.pop_front());
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
            end else if (pending.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (!tail_calm && $urandom_range(0, 15) < send_rate) begin
                send_gap = $urandom_range(0, 17);
                in_bus.valid <= 1'b0;
            end else begin
                in_bus.valid       <= 1'b1;
                in_bus.action      <= pending[0].action;
                in_bus.waiter_id   <= pending[0].waiter_id;
                in_bus.delay_ticks <= pending[0].delay;
            end
        end
        tail_calm <= (pending.size() <= QUIET_TAIL);
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            res_bus.ready <= 1'b0;
        end else if (!tail_calm && $urandom_range(0, 15) < recv_rate) begin
            recv_gap = $urandom_range(0, 17);
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // Idling intensity for both sides is redrawn at each window boundary of window_cnt, including stretches with none.
    always @(posedge i_clk) begin
        window_cnt <= window_cnt + 1;
        if (window_cnt % 64 == 0) begin
            send_rate <= 3 * $urandom_range(0, 2);
            recv_rate <= 3 * $urandom_range(0, 2);
        end
    end

    // Predict on every accepted request beat, then check every result beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready)
                advance_timer_list('{in_bus.action, in_bus.waiter_id, in_bus.delay_ticks});
            if (res_bus.valid && res_bus.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result: id %h status %0d last %0b", $time,
                             res_bus.released_id, res_bus.status, res_bus.last);
                    fail_count++;
                end else begin
                    seen = due_results.pop_front();
                    if (seen.id !== res_bus.released_id || seen.status !== res_bus.status ||
                        seen.last !== res_bus.last) begin
                        $display("%0t: expected id %h status %0d last %0b, %s %h %s %0d %s %0b",
                                 $time, seen.id, seen.status, seen.last,
                                 "got id", res_bus.released_id, "status", res_bus.status,
                                 "last", res_bus.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        int r;
        int made;
        int burst;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.action      = dtq_pkg::ACT_TICK;
        in_bus.waiter_id   = '0;
        in_bus.delay_ticks = '0;
        res_bus.ready      = 1'b0;
        list_len           = 0;
        fail_count         = 0;
        send_gap           = 0;
        recv_gap           = 0;
        send_rate          = 0;
        recv_rate          = 0;
        window_cnt         = 0;
        tail_calm          = 1'b0;

        // Empty queue: tick, flush and the unused code all give nothing released.
        plan(dtq_pkg::ACT_TICK, '0, '0);
        plan(dtq_pkg::ACT_FLUSH, '0, '0);
        plan(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
        // Longest delays, equal deadlines queued in arrival order.
        plan(dtq_pkg::ACT_INSERT, 16'h0000, 16'hFFFF);
        plan(dtq_pkg::ACT_INSERT, 16'h1234, 16'hFFFF);
        plan(dtq_pkg::ACT_INSERT, 16'h5555, 16'd2);
        plan(dtq_pkg::ACT_INSERT, 16'hAAAA, 16'd2);
        // First tick leaves a non-zero head, the second releases two waiters.
        plan(dtq_pkg::ACT_TICK, '0, '0);
        plan(dtq_pkg::ACT_TICK, '0, '0);
        // Zero-delay waiters fill the queue, one more is refused.
        plan(dtq_pkg::ACT_INSERT, 16'hFFFF, '0);
        for (int i = 0; i < 13; i++)
            plan(dtq_pkg::ACT_INSERT, dtq_pkg::ID_W'($urandom), '0);
        plan(dtq_pkg::ACT_INSERT, 16'h0F0F, 16'd1);
        plan(dtq_pkg::ACT_TICK, '0, '0);
        plan(dtq_pkg::ACT_FLUSH, '0, '0);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                burst = $urandom_range(4, 17);
                for (int i = 0; i < burst; i++)
                    plan(dtq_pkg::ACT_INSERT, dtq_pkg::ID_W'($urandom), pick_delay());
                made += burst;
            end else begin
                if (r < 52)
                    plan(dtq_pkg::ACT_INSERT, dtq_pkg::ID_W'($urandom), pick_delay());
                else if (r < 93)
                    plan(dtq_pkg::ACT_TICK, dtq_pkg::ID_W'($urandom),
                         dtq_pkg::DLY_W'($urandom));
                else if (r < 98)
                    plan(dtq_pkg::ACT_FLUSH, dtq_pkg::ID_W'($urandom),
                         dtq_pkg::DLY_W'($urandom));
                else
                    plan(ACT_UNUSED, dtq_pkg::ID_W'($urandom), dtq_pkg::DLY_W'($urandom));
                made++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || due_results.size() != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
